[rtl/tlfas_pkg.sv]
// Shared types and codes for the Thumb load/store fault address sequencer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package tlfas_pkg;

    // number of low registers presented with each instruction
    localparam int LOW_REG_COUNT = 8;
    localparam int REG_IDX_W     = $clog2(LOW_REG_COUNT);

    // result kinds
    localparam logic [2:0] KIND_PAGE      = 3'd0;
    localparam logic [2:0] KIND_STORE     = 3'd1;
    localparam logic [2:0] KIND_LOAD      = 3'd2;
    localparam logic [2:0] KIND_WRITEBACK = 3'd3;
    localparam logic [2:0] KIND_FAIL      = 3'd4;

    // opcode groups: top four bits of the 7-bit opcode (instruction bits 15:12)
    localparam logic [3:0] GRP_LDST_REG = 4'b0101;  // 0b0101'000
    localparam logic [3:0] GRP_IMM_WORD = 4'b0110;  // 0b0110'000
    localparam logic [3:0] GRP_IMM_BYTE = 4'b0111;  // 0b0111'000
    localparam logic [3:0] GRP_IMM_HALF = 4'b1000;  // 0b1000'000
    localparam logic [3:0] GRP_LDM_STM  = 4'b1100;  // 0b1100'000, LDM from 0b1100'100

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch a new instruction beat
        logic emit;     // load the output register with the current result
        logic advance;  // step the register-list scan
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_emit;  // current step produces a result
        logic last;       // that result ends the instruction
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/tlfas_dp.sv]
// Datapath: operand capture, register-list scan, address adder and result register.
// Depends on tlfas_pkg.
`default_nettype none

module tlfas_dp
    import tlfas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [15:0] i_instruction_word,
    input  wire logic [31:0] i_regs [LOW_REG_COUNT],
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_access_address,
    output logic [2:0]       o_register_index,
    output logic [31:0]      o_store_value,
    output logic             o_advance_pc,
    output logic             o_last_result
);

    typedef enum logic [2:0] {
        CLS_SINGLE,
        CLS_STM,
        CLS_LDM,
        CLS_FAIL
    } t_op_class;

    // captured instruction context
    t_op_class              r_cls;
    logic [REG_IDX_W-1:0]   r_rt;
    logic [REG_IDX_W-1:0]   r_base;
    logic                   r_wb;
    logic [31:0]            r_addr;
    logic [31:0]            r_off;
    logic [LOW_REG_COUNT-1:0] r_list;
    logic [REG_IDX_W-1:0]   r_scan;
    logic [31:0]            r_vals [LOW_REG_COUNT];

    // decode of the incoming beat
    t_op_class              n_cls;
    logic [31:0]            n_addr;
    logic [31:0]            n_off;
    logic [4:0]             imm5;
    logic [REG_IDX_W-1:0]   in_rn;
    logic [REG_IDX_W-1:0]   in_rm;
    logic [REG_IDX_W-1:0]   in_base;

    assign imm5    = i_instruction_word[10:6];
    assign in_rn   = i_instruction_word[5:3];
    assign in_rm   = i_instruction_word[8:6];
    assign in_base = i_instruction_word[10:8];

    always_comb begin
        n_cls  = CLS_FAIL;
        n_addr = i_regs[in_rn];
        n_off  = 32'd0;
        unique case (i_instruction_word[15:12])
            GRP_LDST_REG: begin
                n_cls = CLS_SINGLE;
                n_off = i_regs[in_rm];
            end
            GRP_IMM_WORD: begin
                n_cls = CLS_SINGLE;
                n_off = {25'd0, imm5, 2'b00};
            end
            GRP_IMM_BYTE: begin
                n_cls = CLS_SINGLE;
                n_off = {27'd0, imm5};
            end
            GRP_IMM_HALF: begin
                n_cls = CLS_SINGLE;
                n_off = {26'd0, imm5, 1'b0};
            end
            GRP_LDM_STM: begin
                n_cls  = i_instruction_word[11] ? CLS_LDM : CLS_STM;
                n_addr = i_regs[in_base];
            end
            default: begin
                n_cls = CLS_FAIL;
            end
        endcase
    end

    // capture on accept, then shift the list and values down one place per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cls  <= n_cls;
            r_rt   <= i_instruction_word[2:0];
            r_base <= in_base;
            r_wb   <= !i_instruction_word[11] || !i_instruction_word[in_base];
            r_addr <= n_addr;
            r_off  <= n_off;
            r_list <= (n_cls == CLS_STM || n_cls == CLS_LDM) ?
                      i_instruction_word[7:0] : '0;
            r_scan <= '0;
            for (int i = 0; i < LOW_REG_COUNT; i++) begin
                r_vals[i] <= i_regs[i];
            end
        end else if (i_cmd.advance && r_list != '0) begin
            r_list <= {1'b0, r_list[LOW_REG_COUNT-1:1]};
            r_scan <= r_scan + 1'b1;
            if (r_list[0]) begin
                r_addr <= r_addr + 32'd4;
            end
            for (int i = 0; i < LOW_REG_COUNT - 1; i++) begin
                r_vals[i] <= r_vals[i+1];
            end
        end
    end

    // result for the current step
    logic [2:0]  res_kind;
    logic [31:0] res_addr;
    logic [2:0]  res_reg;
    logic [31:0] res_value;
    logic        res_adv;
    logic        res_last;
    logic        need_emit;
    logic        list_tail_empty;

    assign list_tail_empty = (r_list[LOW_REG_COUNT-1:1] == '0);

    always_comb begin
        res_kind  = KIND_FAIL;
        res_addr  = 32'd0;
        res_reg   = 3'd0;
        res_value = 32'd0;
        res_adv   = 1'b0;
        res_last  = 1'b1;
        need_emit = 1'b1;
        case (r_cls)
            CLS_SINGLE: begin
                res_kind = KIND_PAGE;
                res_addr = r_addr + r_off;
                res_reg  = r_rt;
            end
            CLS_STM, CLS_LDM: begin
                if (r_list == '0) begin
                    res_kind = KIND_WRITEBACK;
                    res_addr = r_addr;
                    res_reg  = r_base;
                    res_adv  = 1'b1;
                end else begin
                    need_emit = r_list[0];
                    res_kind  = (r_cls == CLS_STM) ? KIND_STORE : KIND_LOAD;
                    res_addr  = r_addr;
                    res_reg   = r_scan;
                    res_value = (r_cls == CLS_STM) ? r_vals[0] : 32'd0;
                    res_last  = list_tail_empty && !r_wb;
                    res_adv   = res_last;
                end
            end
            default: begin
                res_kind = KIND_FAIL;
            end
        endcase
    end

    assign o_stat = {need_emit, res_last};

    // output register, loaded when the controller issues a result
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result_kind    <= res_kind;
            o_access_address <= res_addr;
            o_register_index <= res_reg;
            o_store_value    <= res_value;
            o_advance_pc     <= res_adv;
            o_last_result    <= res_last;
        end
    end

endmodule

`default_nettype wire

[rtl/tlfas_ctrl.sv]
// Controller: accepts instruction beats and paces result beats through the output register.
// Depends on tlfas_pkg.
`default_nettype none

module tlfas_ctrl
    import tlfas_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;

    // issue commands to the datapath
    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_valid;
        o_cmd.emit    = (r_state == ST_RUN) && i_stat.need_emit && out_free;
        o_cmd.advance = (r_state == ST_RUN) && (!i_stat.need_emit || out_free);
    end

    // next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.emit && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/thumb_ldst_fault_address_sequencer.sv]
// Top level of the Thumb load/store fault address sequencer.
// Depends on tlfas_pkg, tlfas_ctrl and tlfas_dp.
//
// Usage: the input channel (i_valid / o_ready) carries one faulting Thumb
// halfword with the eight low registers per beat. The output channel
// (o_valid / i_ready) carries result beats; o_last_result marks the final
// beat of each instruction. Single loads and stores give one page request,
// unknown opcodes one unrecoverable beat, STM/LDM one beat per listed
// register then an optional base writeback.
// An accepted beat is captured into the datapath registers, then each
// result is loaded into the output register; clear list bits below the
// lowest set one are scanned before the first result. STM/LDM walk the
// register list one position per cycle while the receiver does not
// stall, then give the base writeback if any.
// One instruction is in flight at a time: o_ready is high only between
// instructions, and may rise while the last result still waits in the
// output register.
// Reset clears the controller and drops any pending result. A stalled
// receiver holds the output register; the walk waits at a set list bit.
`default_nettype none

module thumb_ldst_fault_address_sequencer
    import tlfas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_instruction_word,
    input  wire logic [31:0] i_reg0_value,
    input  wire logic [31:0] i_reg1_value,
    input  wire logic [31:0] i_reg2_value,
    input  wire logic [31:0] i_reg3_value,
    input  wire logic [31:0] i_reg4_value,
    input  wire logic [31:0] i_reg5_value,
    input  wire logic [31:0] i_reg6_value,
    input  wire logic [31:0] i_reg7_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_access_address,
    output logic [2:0]       o_register_index,
    output logic [31:0]      o_store_value,
    output logic             o_advance_pc,
    output logic             o_last_result
);

    logic [31:0] regs [LOW_REG_COUNT];
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    // gather the register beat
    assign regs[0] = i_reg0_value;
    assign regs[1] = i_reg1_value;
    assign regs[2] = i_reg2_value;
    assign regs[3] = i_reg3_value;
    assign regs[4] = i_reg4_value;
    assign regs[5] = i_reg5_value;
    assign regs[6] = i_reg6_value;
    assign regs[7] = i_reg7_value;

    tlfas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tlfas_dp u_dp (
        .i_clk              (i_clk),
        .i_instruction_word (i_instruction_word),
        .i_regs             (regs),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_result_kind      (o_result_kind),
        .o_access_address   (o_access_address),
        .o_register_index   (o_register_index),
        .o_store_value      (o_store_value),
        .o_advance_pc       (o_advance_pc),
        .o_last_result      (o_last_result)
    );

endmodule

`default_nettype wire
